// ===== src/ugqi_pkg.sv =====
// Shared constants and types for the uniform grid quadratic interpolator.
package ugqi_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 256;
   localparam int RATIO_BITS          = 16;
   localparam int VALUE_WIDTH         = 32;
   localparam int STEP_WIDTH          = 31;
   localparam int COUNT_WIDTH         = 9;
   localparam int MUL_A_WIDTH         = 35;
   localparam int MUL_B_WIDTH         = 20;
   localparam int MUL_P_WIDTH         = MUL_A_WIDTH + MUL_B_WIDTH;

   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_FILL  = 2'd1;
   localparam logic [1:0] FUNC_EVAL  = 2'd2;

   localparam logic [1:0] CSR_GRID_START  = 2'd0;
   localparam logic [1:0] CSR_GRID_STEP   = 2'd1;
   localparam logic [1:0] CSR_POINT_COUNT = 2'd2;

   localparam logic signed [VALUE_WIDTH-1:0] START_RESET = '0;
   localparam logic [STEP_WIDTH-1:0]         STEP_RESET  = 31'd65536;
   localparam logic [COUNT_WIDTH-1:0]        COUNT_RESET = 9'd256;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   typedef struct packed {
      logic                   we;
      logic [VALUE_WIDTH-1:0] wdata;
   } table_wr_type;

endpackage

// ===== src/ugqi_divstep.sv =====
// One restoring division step shared by the index and ratio divisions.
module ugqi_divstep (
   input  logic [31:0]                        rem_in,
   input  logic                               bit_in,
   input  logic [ugqi_pkg::STEP_WIDTH-1:0]    divisor,
   output logic [31:0]                        rem_out,
   output logic                               qbit
);
   logic [32:0] trial;
   logic [32:0] diff;

   always_comb begin
      trial   = {rem_in, bit_in};
      diff    = trial - 33'(divisor);
      qbit    = (trial >= 33'(divisor));
      rem_out = qbit ? diff[31:0] : trial[31:0];
   end
endmodule

// ===== src/ugqi_mult.sv =====
// Shared signed multiplier with a registered product.
module ugqi_mult (
   input  logic                                       clock,
   input  logic signed [ugqi_pkg::MUL_A_WIDTH-1:0]    mul_a,
   input  logic signed [ugqi_pkg::MUL_B_WIDTH-1:0]    mul_b,
   output logic signed [ugqi_pkg::MUL_P_WIDTH-1:0]    prod_ff
);
   logic signed [ugqi_pkg::MUL_P_WIDTH-1:0] prod_in;

   assign prod_in = ugqi_pkg::MUL_P_WIDTH'(mul_a) * ugqi_pkg::MUL_P_WIDTH'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule

// ===== src/ugqi_table.sv =====
// Sample table memory with one write port and one registered read port.
module ugqi_table #(
   parameter int TABLE_DEPTH = ugqi_pkg::TABLE_DEPTH_DEFAULT,
   localparam int IW = $clog2(TABLE_DEPTH)
) (
   input  logic                                  clock,
   input  ugqi_pkg::table_wr_type                wr,
   input  logic [IW-1:0]                         wr_addr,
   input  logic [IW-1:0]                         rd_addr,
   output logic [ugqi_pkg::VALUE_WIDTH-1:0]      rd_data_ff
);
   logic [ugqi_pkg::VALUE_WIDTH-1:0] mem [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr_addr] <= wr.wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end
endmodule

// ===== src/uniform_grid_quadratic_interpolator_unit.sv =====
// Top level: sequencer, registers and datapath of the grid interpolator.
//
//   port group   dir  handshake            payload
//   req_*        in   req_valid/req_stall  func, coordinate, sample_value
//   rsp_*        out  rsp_valid/rsp_stall  interpolated, status
//   csr_*        in   csr_valid/csr_ready  index, wdata
//
// Write and evaluate run a 32-step restoring division and evaluate also a
// 16-step ratio division, sharing one subtractor; evaluate then makes three
// table reads and three products through one multiplier.
// Fill and the clearing pass after reset sweep all TABLE_DEPTH entries, one entry
// per cycle through the single write port; req_stall is high meanwhile.
// Only one transaction is in flight; req_stall stays high until the result
// is taken. csr_ready is always high.
module uniform_grid_quadratic_interpolator_unit #(
   parameter int TABLE_DEPTH = ugqi_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_func,
   input  logic signed [31:0]  req_coordinate,
   input  logic signed [31:0]  req_sample_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_interpolated,
   output logic                rsp_status,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_wdata
);
   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int NW = $clog2(TABLE_DEPTH + 1);
   localparam int CW = (IW + 1 > 6) ? IW + 1 : 6;
   localparam int AW = ugqi_pkg::MUL_A_WIDTH;
   localparam int BW = ugqi_pkg::MUL_B_WIDTH;
   localparam int PW = ugqi_pkg::MUL_P_WIDTH;
   localparam int RB = ugqi_pkg::RATIO_BITS;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CLEAR = 4'd1;
   localparam logic [3:0] ST_DIV   = 4'd2;
   localparam logic [3:0] ST_CHECK = 4'd3;
   localparam logic [3:0] ST_FRAC  = 4'd4;
   localparam logic [3:0] ST_READ  = 4'd5;
   localparam logic [3:0] ST_MUL   = 4'd6;
   localparam logic [3:0] ST_FIN   = 4'd7;
   localparam logic [3:0] ST_DONE  = 4'd8;

   logic [3:0]                          state_ff, state_in;
   logic [CW-1:0]                       cnt_ff, cnt_in;
   logic [1:0]                          func_ff, func_in;
   logic                                respond_ff, respond_in;
   logic [31:0]                         fill_ff, fill_in;
   logic [31:0]                         dvd_ff, dvd_in;
   logic [31:0]                         rem_ff, rem_in;
   logic [IW-1:0]                       base_ff, base_in;
   logic [1:0]                          j_ff, j_in;
   ugqi_pkg::value_type                 v0_ff, v0_in, v1_ff, v1_in, v2_ff, v2_in;
   logic signed [BW-1:0]                q_ff, q_in;
   logic signed [PW-1:0]                m2_ff, m2_in;
   logic signed [PW:0]                  acc_ff, acc_in;
   logic signed [31:0]                  interp_ff, interp_in;
   logic                                status_ff, status_in;

   logic signed [31:0]                  start_ff;
   logic [ugqi_pkg::STEP_WIDTH-1:0]     step_ff;
   logic [ugqi_pkg::COUNT_WIDTH-1:0]    count_ff;

   logic [ugqi_pkg::STEP_WIDTH-1:0]     step_eff;
   logic [NW-1:0]                       n_eff;
   logic [31:0]                         n32, nm1, nm3;
   logic signed [32:0]                  offset;

   logic [31:0]                         ds_rem_in, ds_rem_out;
   logic                                ds_bit, ds_q;

   logic signed [AW-1:0]                mul_a;
   logic signed [BW-1:0]                mul_b;
   logic signed [PW-1:0]                prod_ff;
   logic [17:0]                         p_val;
   logic signed [BW-1:0]                p_s, pm_s;
   logic signed [AW-1:0]                d1, d2;
   logic signed [PW-1:0]                q_full;
   logic signed [PW:0]                  acc_rnd;
   logic signed [39:0]                  r_wide;

   ugqi_pkg::table_wr_type              tw;
   logic [IW-1:0]                       wr_addr, rd_addr;
   logic [31:0]                         rd_data_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= ugqi_pkg::START_RESET;
         step_ff  <= ugqi_pkg::STEP_RESET;
         count_ff <= ugqi_pkg::COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ugqi_pkg::CSR_GRID_START:  start_ff <= csr_wdata;
            ugqi_pkg::CSR_GRID_STEP:   step_ff  <= csr_wdata[ugqi_pkg::STEP_WIDTH-1:0];
            ugqi_pkg::CSR_POINT_COUNT: count_ff <= csr_wdata[ugqi_pkg::COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      step_eff = (step_ff == '0) ? ugqi_pkg::STEP_WIDTH'(1) : step_ff;
      n32 = 32'(count_ff);
      if (n32 < 32'd3) n32 = 32'd3;
      if (n32 > 32'(TABLE_DEPTH)) n32 = 32'(TABLE_DEPTH);
      n_eff = NW'(n32);
      nm1 = 32'(n_eff) - 32'd1;
      nm3 = 32'(n_eff) - 32'd3;
      offset = 33'(req_coordinate) - 33'(start_ff);
   end

   assign ds_rem_in = rem_ff;
   assign ds_bit    = (state_ff == ST_DIV) ? dvd_ff[31] : 1'b0;

   ugqi_divstep u_divstep (
      .rem_in  (ds_rem_in),
      .bit_in  (ds_bit),
      .divisor (step_eff),
      .rem_out (ds_rem_out),
      .qbit    (ds_q)
   );

   always_comb begin
      p_val  = {j_ff, dvd_ff[15:0]};
      p_s    = BW'($signed({1'b0, p_val}));
      pm_s   = p_s - BW'(1 <<< RB);
      d1     = AW'(v1_ff) - AW'(v0_ff);
      d2     = AW'(v2_ff) - (AW'(v1_ff) <<< 1) + AW'(v0_ff);
      case (cnt_ff[1:0])
         2'd0: begin
            mul_a = AW'(p_s);
            mul_b = pm_s;
         end
         2'd1: begin
            mul_a = d1;
            mul_b = p_s;
         end
         default: begin
            mul_a = d2;
            mul_b = q_ff;
         end
      endcase
      q_full  = (prod_ff + PW'(1 <<< (RB - 1))) >>> RB;
      acc_rnd = (acc_ff + (PW + 1)'(1 <<< RB)) >>> (RB + 1);
      r_wide  = 40'(v0_ff) + 40'(acc_rnd);
   end

   ugqi_mult u_mult (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   always_comb begin
      tw.we    = 1'b0;
      tw.wdata = fill_ff;
      wr_addr  = cnt_ff[IW-1:0];
      rd_addr  = base_ff + IW'(cnt_ff[1:0]);
      if (state_ff == ST_CLEAR) begin
         tw.we = 1'b1;
      end else if (state_ff == ST_CHECK && func_ff == ugqi_pkg::FUNC_WRITE
                   && dvd_ff < 32'(n_eff)) begin
         tw.we   = 1'b1;
         wr_addr = dvd_ff[IW-1:0];
      end
   end

   ugqi_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
      .clock      (clock),
      .wr         (tw),
      .wr_addr    (wr_addr),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data_ff)
   );

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      func_in    = func_ff;
      respond_in = respond_ff;
      fill_in    = fill_ff;
      dvd_in     = dvd_ff;
      rem_in     = rem_ff;
      base_in    = base_ff;
      j_in       = j_ff;
      v0_in      = v0_ff;
      v1_in      = v1_ff;
      v2_in      = v2_ff;
      q_in       = q_ff;
      m2_in      = m2_ff;
      acc_in     = acc_ff;
      interp_in  = interp_ff;
      status_in  = status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in   = req_func;
               interp_in = '0;
               status_in = 1'b0;
               cnt_in    = '0;
               case (req_func)
                  ugqi_pkg::FUNC_FILL: begin
                     fill_in    = req_sample_value;
                     respond_in = 1'b1;
                     state_in   = ST_CLEAR;
                  end
                  ugqi_pkg::FUNC_WRITE, ugqi_pkg::FUNC_EVAL: begin
                     fill_in = req_sample_value;
                     if (offset < 0) begin
                        status_in = 1'b1;
                        state_in  = ST_DONE;
                     end else begin
                        dvd_in   = offset[31:0];
                        rem_in   = '0;
                        state_in = ST_DIV;
                     end
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_CLEAR: begin
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(TABLE_DEPTH - 1)) begin
               state_in = respond_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_DIV: begin
            rem_in = ds_rem_out;
            dvd_in = {dvd_ff[30:0], ds_q};
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(31)) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cnt_in = '0;
            if (func_ff == ugqi_pkg::FUNC_WRITE) begin
               status_in = (dvd_ff >= 32'(n_eff));
               state_in  = ST_DONE;
            end else if (dvd_ff < nm1 || (dvd_ff == nm1 && rem_ff == '0)) begin
               if (dvd_ff <= nm3) begin
                  base_in = dvd_ff[IW-1:0];
                  j_in    = 2'd0;
               end else begin
                  base_in = nm3[IW-1:0];
                  j_in    = 2'(dvd_ff - nm3);
               end
               dvd_in   = '0;
               state_in = ST_FRAC;
            end else begin
               status_in = 1'b1;
               state_in  = ST_DONE;
            end
         end
         ST_FRAC: begin
            rem_in = ds_rem_out;
            dvd_in = {dvd_ff[30:0], ds_q};
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(RB - 1)) begin
               cnt_in   = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cnt_in = cnt_ff + CW'(1);
            case (cnt_ff[1:0])
               2'd1:    v0_in = rd_data_ff;
               2'd2:    v1_in = rd_data_ff;
               2'd3:    v2_in = rd_data_ff;
               default: ;
            endcase
            if (cnt_ff[1:0] == 2'd3) begin
               cnt_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cnt_in = cnt_ff + CW'(1);
            case (cnt_ff[1:0])
               2'd1:    q_in  = BW'(q_full);
               2'd2:    m2_in = prod_ff;
               2'd3: begin
                  acc_in   = ((PW + 1)'(m2_ff) <<< 1) + (PW + 1)'(prod_ff);
                  state_in = ST_FIN;
               end
               default: ;
            endcase
         end
         ST_FIN: begin
            if (r_wide > 40'sd2147483647) interp_in = 32'h7FFF_FFFF;
            else if (r_wide < -40'sd2147483648) interp_in = 32'h8000_0000;
            else interp_in = r_wide[31:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         cnt_ff     <= '0;
         respond_ff <= 1'b0;
         fill_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         respond_ff <= respond_in;
         fill_ff    <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      dvd_ff    <= dvd_in;
      rem_ff    <= rem_in;
      base_ff   <= base_in;
      j_ff      <= j_in;
      v0_ff     <= v0_in;
      v1_ff     <= v1_in;
      v2_ff     <= v2_in;
      q_ff      <= q_in;
      m2_ff     <= m2_in;
      acc_ff    <= acc_in;
      interp_ff <= interp_in;
      status_ff <= status_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = (state_ff == ST_DONE);
   assign rsp_interpolated = interp_ff;
   assign rsp_status       = status_ff;

   a_rsp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while a result is pending");

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff < CW'(32)))
      else $error("division step count overrun");

   a_status_no_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_interpolated == '0))
      else $error("flagged result carries a value");

   a_table_write_src: assert property (@(posedge clock) disable iff (reset)
      tw.we |-> (state_ff == ST_CLEAR || state_ff == ST_CHECK))
      else $error("table written outside clear or store");
endmodule
